FILE: hdl/window_pooling_max_avg_min_assert.svh
// Assertion macros used by the pooling block's checker module.
`ifndef WINDOW_POOLING_MAX_AVG_MIN_ASSERT_SVH
`define WINDOW_POOLING_MAX_AVG_MIN_ASSERT_SVH

// Check that a condition leads to a consequence on the next clock, outside reset.
`define WPOOL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Check what a reset cycle leaves behind on the next clock.
`define WPOOL_ASSERT_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) else $error(msg);

`endif

FILE: hdl/wpool_pkg.sv
package wpool_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int ACC_W         = 22;
    localparam int DIM_W         = 12;
    localparam int COL_W         = 11;
    localparam int IDX_W         = 11;
    localparam int ADDR_W        = 10;
    localparam int STORE_DEPTH   = 1024;
    localparam int CHAN_W        = 10;
    localparam int CNT_CH_W      = 11;
    localparam int WIN_W         = 4;
    localparam int IW_W          = 3;
    localparam int MAX_WINDOW    = 8;
    localparam int MAX_MAP_DIM   = 2048;
    localparam int MAX_CHANNELS  = 1024;
    localparam int RECIP_W       = 19;
    localparam int RECIP_SHIFT   = 18;
    localparam int AVG_RECIP_W   = 29;
    localparam int AVG_SHIFT     = 32;
    localparam int MAG_W         = 21;
    localparam int Q_W           = 17;
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_AW       = 3;
    localparam int FIFO_CNT_W    = 4;
    localparam int SETTLE_CYCLES = 5;
    localparam int SETTLE_W      = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 12;

    typedef enum logic [1:0] {
        MODE_MAX = 2'd0,
        MODE_AVG = 2'd1,
        MODE_MIN = 2'd2
    } t_pool_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POOL_MODE     = 3'd0,
        REG_WINDOW_SIZE   = 3'd1,
        REG_MAP_WIDTH     = 3'd2,
        REG_MAP_HEIGHT    = 3'd3,
        REG_CHANNEL_COUNT = 3'd4
    } t_cfg_reg;

    // Divider settings for the window average.
    typedef struct packed {
        logic [2:0]             shift;
        logic                   unit;
        logic [AVG_RECIP_W-1:0] recip;
    } t_avg_cfg;

    // Control that travels with a finished window into the average path.
    typedef struct packed {
        logic valid;
        logic done;
        logic avg;
    } t_res_ctl;

    typedef struct packed {
        logic valid;
        logic done;
    } t_res_flags;

    typedef struct packed {
        logic                last;
        logic [SAMPLE_W-1:0] value;
    } t_fifo_word;

    // ceil(2^18 / ws): exact quotient for columns below 2048.
    function automatic logic [RECIP_W-1:0] idx_recip(input logic [WIN_W-1:0] ws);
        logic [RECIP_W-1:0] r;
        case (ws)
            4'd1:    r = 19'd262144;
            4'd2:    r = 19'd131072;
            4'd3:    r = 19'd87382;
            4'd4:    r = 19'd65536;
            4'd5:    r = 19'd52429;
            4'd6:    r = 19'd43691;
            4'd7:    r = 19'd37450;
            4'd8:    r = 19'd32768;
            default: r = 19'd262144;
        endcase
        return r;
    endfunction

    // Split ws*ws into a power of two and an odd factor of 1, 9, 25 or 49.
    function automatic t_avg_cfg avg_setup(input logic [WIN_W-1:0] ws);
        t_avg_cfg c;
        c.shift = 3'd0;
        c.unit  = 1'b1;
        c.recip = '0;
        case (ws)
            4'd2:    c.shift = 3'd2;
            4'd3:    begin c.unit = 1'b0; c.recip = 29'd477218589; end
            4'd4:    c.shift = 3'd4;
            4'd5:    begin c.unit = 1'b0; c.recip = 29'd171798692; end
            4'd6:    begin c.shift = 3'd2; c.unit = 1'b0; c.recip = 29'd477218589; end
            4'd7:    begin c.unit = 1'b0; c.recip = 29'd87652394; end
            4'd8:    c.shift = 3'd6;
            default: c.shift = 3'd0;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/window_pooling_max_avg_min.sv
// Non-overlapping square-window pooling (max, average or min) over a pixel stream
// in raster order, channel after channel. The block takes one pixel per clock
// sustained; each window's running partial lives in a 1024-entry column memory
// that is read when a pixel is accepted and written back the cycle after, with a
// bypass for back-to-back pixels of the same window column. A result leaves after
// its window's bottom-right pixel passes the memory read, the update and the
// three-stage average divider, through an eight-word output queue; input stalls
// only while eight results are pending, and while the settle count, restarted by
// reset and by each configuration write, runs down as the derived window limits
// are recomputed. Pixels outside the last full window column or row give no
// result; tlast marks the final result of the last channel.
module window_pooling_max_avg_min (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pixel_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pooled_value
    output logic        m_axis_tlast,   // layer_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [wpool_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wpool_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DPROD_W = wpool_pkg::DIM_W + wpool_pkg::RECIP_W;

    // Configuration registers, raw.
    logic [1:0]                       r_mode;
    logic [wpool_pkg::WIN_W-1:0]      r_ws_raw;
    logic [wpool_pkg::DIM_W-1:0]      r_w_raw;
    logic [wpool_pkg::DIM_W-1:0]      r_h_raw;
    logic [wpool_pkg::CNT_CH_W-1:0]   r_cc_raw;
    logic [wpool_pkg::SETTLE_W-1:0]   r_settle;

    // Derived sizes.
    logic [wpool_pkg::WIN_W-1:0]      r_ws;
    logic [wpool_pkg::DIM_W-1:0]      r_w;
    logic [wpool_pkg::DIM_W-1:0]      r_h;
    logic [wpool_pkg::CNT_CH_W-1:0]   r_cc;
    logic [wpool_pkg::CHAN_W-1:0]     r_cc_m1;
    logic [wpool_pkg::RECIP_W-1:0]    r_recip;
    logic [wpool_pkg::DIM_W-1:0]      r_qw;
    logic [wpool_pkg::DIM_W-1:0]      r_qh;
    logic [wpool_pkg::DIM_W-1:0]      r_wlim;
    logic [wpool_pkg::DIM_W-1:0]      r_hlim;
    wpool_pkg::t_avg_cfg              r_avg_cfg;
    logic [DPROD_W-1:0]               qw_prod;
    logic [DPROD_W-1:0]               qh_prod;
    logic [15:0]                      wlim_prod;
    logic [15:0]                      hlim_prod;

    // Position counters.
    logic [wpool_pkg::COL_W-1:0]      r_col;
    logic [wpool_pkg::COL_W-1:0]      r_row;
    logic [wpool_pkg::IW_W-1:0]       r_riw;
    logic [wpool_pkg::IW_W-1:0]       r_ciw;
    logic [wpool_pkg::CHAN_W-1:0]     r_chan;
    logic [wpool_pkg::IDX_W-1:0]      r_idx;
    logic [wpool_pkg::COL_W-1:0]      n_col;
    logic [wpool_pkg::COL_W-1:0]      n_row;
    logic [wpool_pkg::IW_W-1:0]       n_riw;
    logic [wpool_pkg::IW_W-1:0]       n_ciw;
    logic [wpool_pkg::CHAN_W-1:0]     n_chan;
    logic [wpool_pkg::COL_W-1:0]      idx_col;
    logic [DPROD_W-1:0]               idx_prod;

    logic                             s_acc;
    logic [wpool_pkg::DIM_W-1:0]      col_p1;
    logic [wpool_pkg::DIM_W-1:0]      row_p1;
    logic [wpool_pkg::WIN_W-1:0]      ciw_p1;
    logic [wpool_pkg::WIN_W-1:0]      riw_p1;
    logic [wpool_pkg::CNT_CH_W-1:0]   chan_p1;
    logic [wpool_pkg::WIN_W-1:0]      ws_m1;
    logic                             in_win;
    logic                             s0_first;
    logic                             s0_last;
    logic                             s0_done;

    // Column partial memory and update stage.
    logic [wpool_pkg::ACC_W-1:0]      r_mem [wpool_pkg::STORE_DEPTH];
    logic [wpool_pkg::ACC_W-1:0]      r_rdata;
    logic                             r1_valid;
    logic [wpool_pkg::SAMPLE_W-1:0]   r1_px;
    logic [wpool_pkg::IDX_W-1:0]      r1_idx;
    logic                             r1_first;
    logic                             r1_last;
    logic                             r1_done;
    logic                             r1_fwd;
    logic [wpool_pkg::ACC_W-1:0]      r1_fwd_data;
    logic [wpool_pkg::ACC_W-1:0]      px_ext;
    logic [wpool_pkg::ACC_W-1:0]      prev;
    logic [wpool_pkg::ACC_W-1:0]      sum;
    logic                             px_lt;
    logic [wpool_pkg::ACC_W-1:0]      acc;
    logic                             wr_en;
    wpool_pkg::t_res_ctl              res_ctl;
    wpool_pkg::t_res_flags            avg_flags;
    logic [wpool_pkg::SAMPLE_W-1:0]   avg_value;

    // Output queue.
    wpool_pkg::t_fifo_word            r_fifo [wpool_pkg::FIFO_DEPTH];
    logic [wpool_pkg::FIFO_AW-1:0]    r_wr_ptr;
    logic [wpool_pkg::FIFO_AW-1:0]    r_rd_ptr;
    logic [wpool_pkg::FIFO_CNT_W-1:0] r_count;
    logic [wpool_pkg::FIFO_CNT_W-1:0] r_pend;
    logic                             pend_inc;
    logic                             m_acc;
    wpool_pkg::t_fifo_word            head;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers and restart the settle count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= wpool_pkg::MODE_MAX;
            r_ws_raw <= 4'd2;
            r_w_raw  <= 12'd32;
            r_h_raw  <= 12'd32;
            r_cc_raw <= 11'd1;
            r_settle <= wpool_pkg::SETTLE_W'(wpool_pkg::SETTLE_CYCLES);
        end else if (i_cfg_valid) begin
            r_settle <= wpool_pkg::SETTLE_W'(wpool_pkg::SETTLE_CYCLES);
            case (i_cfg_index)
                wpool_pkg::REG_POOL_MODE:     r_mode   <= i_cfg_data[1:0];
                wpool_pkg::REG_WINDOW_SIZE:   r_ws_raw <= i_cfg_data[wpool_pkg::WIN_W-1:0];
                wpool_pkg::REG_MAP_WIDTH:     r_w_raw  <= i_cfg_data;
                wpool_pkg::REG_MAP_HEIGHT:    r_h_raw  <= i_cfg_data;
                wpool_pkg::REG_CHANNEL_COUNT: r_cc_raw <= i_cfg_data[wpool_pkg::CNT_CH_W-1:0];
                default:                      r_mode   <= r_mode;
            endcase
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    // Derive clamped sizes and window limits through a chain of registers.
    assign qw_prod   = DPROD_W'(r_w) * DPROD_W'(r_recip);
    assign qh_prod   = DPROD_W'(r_h) * DPROD_W'(r_recip);
    assign wlim_prod = 16'(r_qw) * 16'(r_ws);
    assign hlim_prod = 16'(r_qh) * 16'(r_ws);

    always_ff @(posedge i_clk) begin
        if (r_ws_raw == '0)
            r_ws <= 4'd1;
        else if (r_ws_raw > wpool_pkg::WIN_W'(wpool_pkg::MAX_WINDOW))
            r_ws <= wpool_pkg::WIN_W'(wpool_pkg::MAX_WINDOW);
        else
            r_ws <= r_ws_raw;
        if (r_w_raw == '0)
            r_w <= 12'd1;
        else if (r_w_raw > wpool_pkg::DIM_W'(wpool_pkg::MAX_MAP_DIM))
            r_w <= wpool_pkg::DIM_W'(wpool_pkg::MAX_MAP_DIM);
        else
            r_w <= r_w_raw;
        if (r_h_raw == '0)
            r_h <= 12'd1;
        else if (r_h_raw > wpool_pkg::DIM_W'(wpool_pkg::MAX_MAP_DIM))
            r_h <= wpool_pkg::DIM_W'(wpool_pkg::MAX_MAP_DIM);
        else
            r_h <= r_h_raw;
        if (r_cc_raw == '0)
            r_cc <= 11'd1;
        else if (r_cc_raw > wpool_pkg::CNT_CH_W'(wpool_pkg::MAX_CHANNELS))
            r_cc <= wpool_pkg::CNT_CH_W'(wpool_pkg::MAX_CHANNELS);
        else
            r_cc <= r_cc_raw;
        r_cc_m1   <= wpool_pkg::CHAN_W'(r_cc - 1'b1);
        r_recip   <= wpool_pkg::idx_recip(r_ws);
        r_avg_cfg <= wpool_pkg::avg_setup(r_ws);
        r_qw      <= qw_prod[wpool_pkg::RECIP_SHIFT+wpool_pkg::DIM_W-1:wpool_pkg::RECIP_SHIFT];
        r_qh      <= qh_prod[wpool_pkg::RECIP_SHIFT+wpool_pkg::DIM_W-1:wpool_pkg::RECIP_SHIFT];
        r_wlim    <= wlim_prod[wpool_pkg::DIM_W-1:0];
        r_hlim    <= hlim_prod[wpool_pkg::DIM_W-1:0];
    end

    assign s_axis_tready = (r_settle == '0) &&
                           (r_pend < wpool_pkg::FIFO_CNT_W'(wpool_pkg::FIFO_DEPTH));
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // Classify the accepted pixel against its window.
    assign col_p1   = {1'b0, r_col} + 1'b1;
    assign row_p1   = {1'b0, r_row} + 1'b1;
    assign ciw_p1   = {1'b0, r_ciw} + 1'b1;
    assign riw_p1   = {1'b0, r_riw} + 1'b1;
    assign chan_p1  = {1'b0, r_chan} + 1'b1;
    assign ws_m1    = r_ws - 1'b1;
    assign in_win   = ({1'b0, r_col} < r_wlim) && ({1'b0, r_row} < r_hlim);
    assign s0_first = (r_riw == '0) && (r_ciw == '0);
    assign s0_last  = ({1'b0, r_riw} == ws_m1) && ({1'b0, r_ciw} == ws_m1);
    assign s0_done  = (r_chan == r_cc_m1) && (row_p1 == r_hlim) && (col_p1 == r_wlim);

    // Advance the raster and in-window counters.
    always_comb begin
        n_ciw  = (ciw_p1 >= r_ws) ? '0 : ciw_p1[wpool_pkg::IW_W-1:0];
        n_riw  = r_riw;
        n_col  = col_p1[wpool_pkg::COL_W-1:0];
        n_row  = r_row;
        n_chan = r_chan;
        if (col_p1 >= r_w) begin
            n_col = '0;
            n_ciw = '0;
            n_riw = (riw_p1 >= r_ws) ? '0 : riw_p1[wpool_pkg::IW_W-1:0];
            if (row_p1 >= r_h) begin
                n_row  = '0;
                n_riw  = '0;
                n_chan = (chan_p1 >= r_cc) ? '0 : chan_p1[wpool_pkg::CHAN_W-1:0];
            end else begin
                n_row = row_p1[wpool_pkg::COL_W-1:0];
            end
        end
    end

    // Window column of the pixel that comes next.
    assign idx_col  = s_acc ? n_col : r_col;
    assign idx_prod = DPROD_W'(idx_col) * DPROD_W'(r_recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_riw  <= '0;
            r_ciw  <= '0;
            r_chan <= '0;
        end else if (s_acc) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_riw  <= n_riw;
            r_ciw  <= n_ciw;
            r_chan <= n_chan;
        end
        r_idx <= idx_prod[wpool_pkg::RECIP_SHIFT+wpool_pkg::IDX_W-1:wpool_pkg::RECIP_SHIFT];
    end

    // Read the partial for the accepted pixel; write back the updated one.
    always_ff @(posedge i_clk) begin
        if (s_acc)
            r_rdata <= r_mem[r_idx[wpool_pkg::ADDR_W-1:0]];
        if (wr_en)
            r_mem[r1_idx[wpool_pkg::ADDR_W-1:0]] <= acc;
    end

    // Hold the pixel for the update stage; bypass a write to the same column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= s_acc && in_win;
        end
        r1_px       <= s_axis_tdata;
        r1_idx      <= r_idx;
        r1_first    <= s0_first;
        r1_last     <= s0_last;
        r1_done     <= s0_done;
        r1_fwd      <= wr_en && (r1_idx == r_idx);
        r1_fwd_data <= acc;
    end

    // Combine the pixel with the window's partial.
    assign px_ext = {{(wpool_pkg::ACC_W-wpool_pkg::SAMPLE_W){r1_px[wpool_pkg::SAMPLE_W-1]}}, r1_px};
    assign prev   = r1_idx[wpool_pkg::IDX_W-1] ? '0 : (r1_fwd ? r1_fwd_data : r_rdata);
    assign sum    = prev + px_ext;
    assign px_lt  = $signed(px_ext) < $signed(prev);

    always_comb begin
        if (r1_first)
            acc = px_ext;
        else if (r_mode == wpool_pkg::MODE_AVG)
            acc = sum;
        else if (r_mode == wpool_pkg::MODE_MIN)
            acc = px_lt ? px_ext : prev;
        else
            acc = px_lt ? prev : px_ext;
    end

    assign wr_en = r1_valid && !r1_last && !r1_idx[wpool_pkg::IDX_W-1];

    assign res_ctl.valid = r1_valid && r1_last;
    assign res_ctl.done  = r1_done;
    assign res_ctl.avg   = (r_mode == wpool_pkg::MODE_AVG);

    wpool_avg u_avg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (res_ctl),
        .i_acc     (acc),
        .i_avg_cfg (r_avg_cfg),
        .o_flags   (avg_flags),
        .o_value   (avg_value)
    );

    // Queue finished words; count results owed so the queue never overflows.
    assign m_acc    = m_axis_tvalid && m_axis_tready;
    assign pend_inc = s_acc && in_win && s0_last;
    assign head     = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_pend   <= '0;
        end else begin
            if (avg_flags.valid)
                r_wr_ptr <= r_wr_ptr + 1'b1;
            if (m_acc)
                r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + FIFO_INC(avg_flags.valid) - FIFO_INC(m_acc);
            r_pend  <= r_pend + FIFO_INC(pend_inc) - FIFO_INC(m_acc);
        end
        if (avg_flags.valid)
            r_fifo[r_wr_ptr] <= '{last: avg_flags.done, value: avg_value};
    end

    function automatic logic [wpool_pkg::FIFO_CNT_W-1:0] FIFO_INC(input logic b);
        return {{(wpool_pkg::FIFO_CNT_W-1){1'b0}}, b};
    endfunction

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = head.value;
    assign m_axis_tlast  = head.last;

endmodule

FILE: hdl/wpool_avg.sv
module wpool_avg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wpool_pkg::t_res_ctl          i_ctl,
    input  logic [wpool_pkg::ACC_W-1:0]  i_acc,
    input  wpool_pkg::t_avg_cfg          i_avg_cfg,
    output wpool_pkg::t_res_flags        o_flags,
    output logic [wpool_pkg::SAMPLE_W-1:0] o_value
);

    localparam int PROD_W = wpool_pkg::MAG_W + wpool_pkg::AVG_RECIP_W;

    logic [wpool_pkg::ACC_W-1:0]    mag;
    logic [wpool_pkg::ACC_W-1:0]    mag_sh;
    logic [PROD_W-1:0]              prod;
    logic [wpool_pkg::Q_W-1:0]      quot;
    logic [wpool_pkg::Q_W-1:0]      quot_s;

    wpool_pkg::t_res_ctl            r2_ctl;
    logic [wpool_pkg::MAG_W-1:0]    r2_mag;
    logic                           r2_neg;
    logic [wpool_pkg::SAMPLE_W-1:0] r2_val;

    wpool_pkg::t_res_ctl            r3_ctl;
    logic [wpool_pkg::Q_W-1:0]      r3_q;
    logic                           r3_neg;
    logic [wpool_pkg::SAMPLE_W-1:0] r3_val;

    wpool_pkg::t_res_flags          r4_flags;
    logic [wpool_pkg::SAMPLE_W-1:0] r4_value;

    // Take the magnitude and strip the power-of-two part of the divisor.
    assign mag    = i_acc[wpool_pkg::ACC_W-1] ? (~i_acc + 1'b1) : i_acc;
    assign mag_sh = mag >> i_avg_cfg.shift;

    // Divide by the odd factor with a reciprocal multiply.
    assign prod = PROD_W'(r2_mag) * PROD_W'(i_avg_cfg.recip);
    assign quot = i_avg_cfg.unit ? r2_mag[wpool_pkg::Q_W-1:0]
                                 : prod[wpool_pkg::AVG_SHIFT+wpool_pkg::Q_W-1:wpool_pkg::AVG_SHIFT];

    // Restore the sign, truncating toward zero.
    assign quot_s = r3_neg ? (~r3_q + 1'b1) : r3_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl   <= '0;
            r3_ctl   <= '0;
            r4_flags <= '0;
        end else begin
            r2_ctl         <= i_ctl;
            r3_ctl         <= r2_ctl;
            r4_flags.valid <= r3_ctl.valid;
            r4_flags.done  <= r3_ctl.done;
        end
        r2_mag   <= mag_sh[wpool_pkg::MAG_W-1:0];
        r2_neg   <= i_acc[wpool_pkg::ACC_W-1];
        r2_val   <= i_acc[wpool_pkg::SAMPLE_W-1:0];
        r3_q     <= quot;
        r3_neg   <= r2_neg;
        r3_val   <= r2_val;
        r4_value <= r3_ctl.avg ? quot_s[wpool_pkg::SAMPLE_W-1:0] : r3_val;
    end

    assign o_flags = r4_flags;
    assign o_value = r4_value;

endmodule

FILE: hdl/wpool_chk.sv
`include "window_pooling_max_avg_min_assert.svh"

module wpool_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    // Hold a stalled result word.
    `WPOOL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result word changed")

    // Pause input while new settings propagate.
    `WPOOL_ASSERT_NEXT(a_cfg_pause, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, !s_axis_tready, "input taken right after a configuration write")

    // Leave reset with an empty queue and a paused input.
    `WPOOL_ASSERT_RESET(a_reset_clear, i_clk, i_rst_n, !m_axis_tvalid && !s_axis_tready, "queue or input not idle after reset")

    // Refuse input during the cycle after a reset cycle releases.
    `WPOOL_ASSERT_NEXT(a_rst_release, i_clk, i_rst_n, $rose(i_rst_n), !s_axis_tready, "input taken during settle after reset")

    // Never take input in the same cycle as a configuration write.
    `WPOOL_ASSERT_NEXT(a_no_input_settle, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, $past(!(i_cfg_valid && o_cfg_ready)), "input accepted while settings were changing")

endmodule

bind window_pooling_max_avg_min wpool_chk u_wpool_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);

FILE: tb/sv/pool_checker.sv
`timescale 1ns / 1ps

// Watches the pixel, result and register channels of the pooling block, keeps
// its own copy of the window state, and compares every pooled word in order.
module pool_checker
    import wpool_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pix_valid,
    input  logic                 i_pix_ready,
    input  logic [SAMPLE_W-1:0]  i_pix_data,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [SAMPLE_W-1:0]  i_res_data,
    input  logic                 i_res_last,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                   o_pending,
    output int                   o_errors,
    output int                   o_checked
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                done;
    } pooled_t;

    pooled_t pooled_q[$];

    // Register copies, held at their port widths
    logic [1:0]          mode_r;
    logic [WIN_W-1:0]    win_r;
    logic [DIM_W-1:0]    width_r;
    logic [DIM_W-1:0]    height_r;
    logic [CNT_CH_W-1:0] chans_r;

    // Window position and per-column partials
    logic signed [ACC_W-1:0] col_part [STORE_DEPTH];
    logic [COL_W-1:0]  px_col;
    logic [COL_W-1:0]  px_row;
    logic [IW_W-1:0]   row_iw;
    logic [IW_W-1:0]   col_iw;
    logic [CHAN_W-1:0] chan_idx;

    int errors  = 0;
    int checked = 0;

    function automatic int limit(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Fold one accepted pixel into its window; queue a pooled word when it closes one.
    task automatic pool_pixel(input logic [SAMPLE_W-1:0] raw);
        int ws, w, h, cc, span_w, span_h, idx, quot;
        logic signed [ACC_W-1:0] px, acc, prev;
        logic first, last;
        pooled_t r;
        ws = limit(win_r, MAX_WINDOW);
        w  = limit(width_r, MAX_MAP_DIM);
        h  = limit(height_r, MAX_MAP_DIM);
        cc = limit(chans_r, MAX_CHANNELS);
        span_w = (w / ws) * ws;
        span_h = (h / ws) * ws;
        px = $signed(raw);
        if (px_col < span_w && px_row < span_h) begin
            idx   = px_col / ws;
            first = (row_iw == 0) && (col_iw == 0);
            last  = (row_iw == ws - 1) && (col_iw == ws - 1);
            acc   = px;
            if (!first) begin
                prev = (idx < STORE_DEPTH) ? col_part[idx] : '0;
                if (mode_r == MODE_AVG)
                    acc = prev + px;
                else if (mode_r == MODE_MIN)
                    acc = (px < prev) ? px : prev;
                else
                    acc = (px > prev) ? px : prev;
            end
            if (last) begin
                quot = acc;
                if (mode_r == MODE_AVG)
                    quot = quot / (ws * ws);
                r.value = quot[SAMPLE_W-1:0];
                r.done  = (chan_idx == cc - 1) && (px_row == span_h - 1) &&
                          (px_col == span_w - 1);
                pooled_q.push_back(r);
            end else if (idx < STORE_DEPTH) begin
                col_part[idx] = acc;
            end
        end
        // Advance the raster position
        col_iw = (col_iw + 1 >= ws) ? '0 : col_iw + 1'b1;
        if (px_col + 1 >= w) begin
            px_col = '0;
            col_iw = '0;
            row_iw = (row_iw + 1 >= ws) ? '0 : row_iw + 1'b1;
            if (px_row + 1 >= h) begin
                px_row   = '0;
                row_iw   = '0;
                chan_idx = (chan_idx + 1 >= cc) ? '0 : chan_idx + 1'b1;
            end else begin
                px_row = px_row + 1'b1;
            end
        end else begin
            px_col = px_col + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        pooled_t exp_word;
        if (!i_rst_n) begin
            mode_r   = MODE_MAX;
            win_r    = 4'd2;
            width_r  = 12'd32;
            height_r = 12'd32;
            chans_r  = 11'd1;
            px_col   = '0;
            px_row   = '0;
            row_iw   = '0;
            col_iw   = '0;
            chan_idx = '0;
            pooled_q.delete();
        end else begin
            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_POOL_MODE:     mode_r   = i_cfg_data[1:0];
                    REG_WINDOW_SIZE:   win_r    = i_cfg_data[WIN_W-1:0];
                    REG_MAP_WIDTH:     width_r  = i_cfg_data[DIM_W-1:0];
                    REG_MAP_HEIGHT:    height_r = i_cfg_data[DIM_W-1:0];
                    REG_CHANNEL_COUNT: chans_r  = i_cfg_data[CNT_CH_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready)
                pool_pixel(i_pix_data);
            // Compare each pooled word with the oldest expectation
            if (i_res_valid && i_res_ready) begin
                if (pooled_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("pool_checker: unexpected word %h last %b",
                                 i_res_data, i_res_last);
                end else begin
                    exp_word = pooled_q.pop_front();
                    checked++;
                    if (i_res_data !== exp_word.value || i_res_last !== exp_word.done) begin
                        errors++;
                        if (errors <= 10)
                            $display("pool_checker: word %0d expected %h last %b, got %h last %b",
                                     checked, exp_word.value, exp_word.done,
                                     i_res_data, i_res_last);
                    end
                end
            end
        end
        o_pending <= pooled_q.size();
        o_errors  <= errors;
        o_checked <= checked;
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import wpool_pkg::*;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata   = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b1;
    logic [SAMPLE_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    int pending;
    int errors;
    int checked;

    logic idle_on     = 1'b1;
    int   hold_cycles = 0;
    int   pixels_sent = 0;
    int   reg_writes  = 0;
    int   cur_ws, cur_w, cur_h, cur_cc;

    window_pooling_max_avg_min u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    pool_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (s_axis_tvalid),
        .i_pix_ready (s_axis_tready),
        .i_pix_data  (s_axis_tdata),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_res_last  (m_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_checked   (checked)
    );

    always #10 i_clk = ~i_clk;

    // Result side: stall in random bursts while idling is on
    always @(posedge i_clk) begin
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else if (hold_cycles != 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #20_000_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic int eff(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic int layer_pixels();
        return eff(cur_cc, MAX_CHANNELS) * eff(cur_w, MAX_MAP_DIM) * eff(cur_h, MAX_MAP_DIM);
    endfunction

    // Mix of full-scale, near-zero and uniform samples
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 7))
            0:       s = 16'h8000;
            1:       s = 16'h7FFF;
            2:       s = 16'($urandom_range(0, 8)) - 16'd4;
            default: s = 16'($urandom);
        endcase
        return s;
    endfunction

    // Offer one pixel word, with an occasional gap ahead of it while idling is on
    task automatic send_pixel(input logic [SAMPLE_W-1:0] value);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic stream_pixels(input int count);
        repeat (count) send_pixel(pick_sample());
    endtask

    // Drop valid, wait out every expected word, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg index, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        reg_writes++;
    endtask

    // Write all five registers; valid stays high across the burst
    task automatic set_pooling(input int mode, input int ws, input int w, input int h,
                               input int cc);
        write_reg(REG_POOL_MODE, mode);
        write_reg(REG_WINDOW_SIZE, ws);
        write_reg(REG_MAP_WIDTH, w);
        write_reg(REG_MAP_HEIGHT, h);
        write_reg(REG_CHANNEL_COUNT, cc);
        i_cfg_valid <= 1'b0;
        cur_ws = ws;
        cur_w  = w;
        cur_h  = h;
        cur_cc = cc;
    endtask

    task automatic random_pooling();
        int ws, wse, w, h, cc;
        case ($urandom_range(0, 11))
            0:       ws = 0;
            1:       ws = $urandom_range(9, 15);
            default: ws = $urandom_range(1, MAX_WINDOW);
        endcase
        wse = eff(ws, MAX_WINDOW);
        w  = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 2 * wse + 2);
        h  = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, wse + 1);
        cc = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 2);
        set_pooling($urandom_range(0, 3), ws, w, h, cc);
    endtask

    initial begin
        int n, k, rand_sent;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Max over a window holding both extremes
        set_pooling(MODE_MAX, 2, 2, 2, 1);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        settle();

        // Min over the same window
        set_pooling(MODE_MIN, 2, 2, 2, 1);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        settle();

        // Average of a negative sum truncates toward zero
        set_pooling(MODE_AVG, 2, 2, 2, 1);
        send_pixel(16'h8000);
        send_pixel(16'h8000);
        send_pixel(16'h8000);
        send_pixel(16'h8001);
        settle();

        // Spare mode with zero sizes, two one-pixel layers back to back
        set_pooling(3, 0, 0, 0, 0);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        settle();

        // Leftover column and row dropped
        set_pooling(MODE_MAX, 2, 3, 3, 1);
        stream_pixels(9);
        settle();

        // Map narrower than the clamped window gives nothing
        set_pooling(MODE_AVG, 15, 3, 1, 1);
        stream_pixels(3);
        settle();

        // Widest row, which also fills every column partial
        set_pooling(MODE_AVG, 2, 4095, 2, 1);
        stream_pixels(layer_pixels());
        settle();

        // Tallest column
        set_pooling(MODE_MIN, 1, 1, 4095, 1);
        stream_pixels(layer_pixels());
        settle();

        // Most channels
        set_pooling(3, 1, 1, 1, 2047);
        stream_pixels(layer_pixels());
        settle();

        // Random layers, some reconfigured partway through
        rand_sent = 0;
        while (rand_sent < 600) begin
            if (rand_sent >= 480)
                idle_on <= 1'b0;
            else
                idle_on <= ($urandom_range(0, 3) != 0);
            random_pooling();
            n = layer_pixels() * $urandom_range(1, 2);
            if (n > 1 && $urandom_range(0, 4) == 0) begin
                k = $urandom_range(1, n - 1);
                stream_pixels(k);
                settle();
                random_pooling();
                n = $urandom_range(1, 40);
                stream_pixels(n);
                settle();
                // Single-pixel layer returns every position counter to zero
                set_pooling(MODE_MAX, 1, 1, 1, 1);
                send_pixel(pick_sample());
                settle();
                rand_sent += k + n + 1;
            end else begin
                stream_pixels(n);
                settle();
                rand_sent += n;
            end
        end

        $display("summary: %0d pixel words in, %0d pooled words checked, %0d register writes",
                 pixels_sent, checked, reg_writes);
        $display("summary: max/avg/min/spare modes, windows 1-8 and clamped, edge sizes, mid-layer changes");
        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/wpool_pkg.sv
hdl/wpool_avg.sv
hdl/window_pooling_max_avg_min.sv
hdl/wpool_chk.sv
tb/sv/pool_checker.sv
tb/sv/testbench.sv
